/* hdl/bdeq_pkg.sv */
// Shared types and constants for the bounded double-ended queue.
`default_nettype none

package bdeq_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int DATA_W        = 32;
  localparam int ACTION_W      = 3;
  localparam int STATUS_W      = 2;
  localparam int OCC_W         = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INS_FRONT  = 3'd0,
    ACT_INS_BACK   = 3'd1,
    ACT_REM_FRONT  = 3'd2,
    ACT_REM_BACK   = 3'd3,
    ACT_PEEK_FRONT = 3'd4,
    ACT_PEEK_BACK  = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // Broadcast command to every cell of the chain.
  typedef struct packed {
    logic shift_right;  // insert at front: every entry moves one cell back
    logic shift_left;   // remove at front: every entry moves one cell forward
    logic write_back;   // insert at back: the cell at the current count loads
  } cell_cmd_t;

endpackage

`default_nettype wire

/* hdl/bounded_double_ended_queue.sv */
// Top level of the bounded double-ended queue: a chain of shifting storage cells.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+---------------------------------------
//   in      | into      | in_valid_i / in_stall_o  | action_i, data_in_i
//   out     | out of    | out_valid_o / out_stall_i| status_o, data_out_o, occupancy_o,
//           |           |                          | is_empty_flag_o, is_full_flag_o
//
// One transfer per cycle while in_stall_o is low: an operation is taken in one cycle and its result is
// registered, shown the cycle after. The chain shifts all cells in that same cycle.
// in_stall_o rises only while a result sits in the output register and out is stalled.
// Reset (async, active low) clears the entry count and the output valid; the cells
// themselves are not cleared, and no clearing pass runs.
`default_nettype none

module bounded_double_ended_queue #(
  parameter int DEPTH = bdeq_pkg::DEFAULT_DEPTH
) (
  input  wire                                     clk_i,
  input  wire                                     rst_ni,
  input  wire                                     in_valid_i,
  output logic                                    in_stall_o,
  input  wire [bdeq_pkg::ACTION_W-1:0]            action_i,
  input  wire signed [bdeq_pkg::DATA_W-1:0]       data_in_i,
  output logic                                    out_valid_o,
  input  wire                                     out_stall_i,
  output logic [bdeq_pkg::STATUS_W-1:0]           status_o,
  output logic signed [bdeq_pkg::DATA_W-1:0]      data_out_o,
  output logic [bdeq_pkg::OCC_W-1:0]              occupancy_o,
  output logic                                    is_empty_flag_o,
  output logic                                    is_full_flag_o
);

  localparam int CntW  = $clog2(DEPTH + 1);
  localparam int DataW = bdeq_pkg::DATA_W;

  // Cell i holds the entry at distance i from the front. Front inserts and
  // removes shift the whole chain; back inserts load the cell at the count.
  logic [DataW-1:0]     cell_val  [DEPTH];
  logic [DataW-1:0]     cell_tail [DEPTH];
  logic [DEPTH-1:0]     tail_col  [DataW];
  logic [DataW-1:0]     back_val;
  logic [DataW-1:0]     data_in;
  logic [CntW-1:0]      count;
  bdeq_pkg::cell_cmd_t  cmd;

  assign data_in = data_in_i;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DataW-1:0] prev_val, next_val;

    if (i == 0) begin : g_first
      assign prev_val = data_in;
    end else begin : g_mid
      assign prev_val = cell_val[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign next_val = '0;
    end else begin : g_inner
      assign next_val = cell_val[i+1];
    end

    bdeq_cell #(
      .DEPTH (DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk_i     (clk_i),
      .cmd_i     (cmd),
      .count_i   (count),
      .data_in_i (data_in),
      .prev_i    (prev_val),
      .next_i    (next_val),
      .value_o   (cell_val[i]),
      .tail_o    (cell_tail[i])
    );
  end

  // Back entry: at most one cell flags itself as tail (none while empty), so OR the columns.
  for (genvar b = 0; b < DataW; b++) begin : g_back
    for (genvar i = 0; i < DEPTH; i++) begin : g_col
      assign tail_col[b][i] = cell_tail[i][b];
    end
    assign back_val[b] = |tail_col[b];
  end

  bdeq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .action_i        (action_i),
    .front_i         (cell_val[0]),
    .back_i          (back_val),
    .cmd_o           (cmd),
    .count_o         (count),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .data_out_o      (data_out_o),
    .occupancy_o     (occupancy_o),
    .is_empty_flag_o (is_empty_flag_o),
    .is_full_flag_o  (is_full_flag_o)
  );

`ifndef ASSERT_OFF
  logic in_xfer;
  assign in_xfer = in_valid_i && !in_stall_o;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CntW'(DEPTH))
    else $error("entry count beyond capacity");

  a_xfer_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> out_valid_o)
    else $error("accepted operation gave no result");

  a_full_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && count == CntW'(DEPTH) &&
    (action_i == bdeq_pkg::ACT_INS_FRONT || action_i == bdeq_pkg::ACT_INS_BACK)
    |=> status_o == bdeq_pkg::ST_FULL && count == $past(count))
    else $error("insert on full queue not rejected");

  a_front_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && count != '0 && action_i == bdeq_pkg::ACT_REM_FRONT
    |=> data_out_o == $past(cell_val[0]) && count == $past(count) - CntW'(1))
    else $error("front remove returned wrong entry");
`endif

endmodule

`default_nettype wire

/* hdl/bdeq_cell.sv */
// One storage cell of the queue chain; cell 0 holds the front entry.
`default_nettype none

module bdeq_cell #(
  parameter int DEPTH = bdeq_pkg::DEFAULT_DEPTH,
  parameter int IDX   = 0
) (
  input  wire                                clk_i,
  input  wire bdeq_pkg::cell_cmd_t           cmd_i,
  input  wire [$clog2(DEPTH+1)-1:0]          count_i,
  input  wire [bdeq_pkg::DATA_W-1:0]         data_in_i,
  input  wire [bdeq_pkg::DATA_W-1:0]         prev_i,   // neighbor toward the front
  input  wire [bdeq_pkg::DATA_W-1:0]         next_i,   // neighbor toward the back
  output logic [bdeq_pkg::DATA_W-1:0]        value_o,
  output logic [bdeq_pkg::DATA_W-1:0]        tail_o    // own value if this is the back
);

  localparam int CntW = $clog2(DEPTH + 1);

  logic [bdeq_pkg::DATA_W-1:0] value_q, value_d;
  logic                        is_slot, is_tail;

  assign is_slot = (count_i == CntW'(IDX));
  assign is_tail = (count_i == CntW'(IDX + 1));

  always_comb begin
    value_d = value_q;
    if (cmd_i.shift_right) begin
      value_d = prev_i;
    end else if (cmd_i.shift_left) begin
      value_d = next_i;
    end else if (cmd_i.write_back && is_slot) begin
      value_d = data_in_i;
    end
  end

  // payload only, no reset
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  assign tail_o  = is_tail ? value_q : '0;

endmodule

`default_nettype wire

/* hdl/bdeq_ctrl.sv */
// Operation decode, entry count and result register of the queue.
`default_nettype none

module bdeq_ctrl #(
  parameter int DEPTH = bdeq_pkg::DEFAULT_DEPTH
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                in_valid_i,
  output logic                               in_stall_o,
  input  wire [bdeq_pkg::ACTION_W-1:0]       action_i,
  input  wire [bdeq_pkg::DATA_W-1:0]         front_i,
  input  wire [bdeq_pkg::DATA_W-1:0]         back_i,
  output bdeq_pkg::cell_cmd_t                cmd_o,
  output logic [$clog2(DEPTH+1)-1:0]         count_o,
  output logic                               out_valid_o,
  input  wire                                out_stall_i,
  output logic [bdeq_pkg::STATUS_W-1:0]      status_o,
  output logic [bdeq_pkg::DATA_W-1:0]        data_out_o,
  output logic [bdeq_pkg::OCC_W-1:0]         occupancy_o,
  output logic                               is_empty_flag_o,
  output logic                               is_full_flag_o
);

  localparam int CntW = $clog2(DEPTH + 1);
  localparam int OccW = bdeq_pkg::OCC_W;

  logic [CntW-1:0]                count_q, count_d;
  logic                           out_valid_q, out_valid_d;
  logic [bdeq_pkg::STATUS_W-1:0]  status_q, status_d;
  logic [bdeq_pkg::DATA_W-1:0]    data_q, data_d;
  logic [OccW-1:0]                occ_q;
  logic                           empty_q, full_q;
  logic [OccW+CntW-1:0]           occ_wide;
  logic                           accept, full, empty;
  bdeq_pkg::cell_cmd_t            cmd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);

  always_comb begin
    cmd      = '0;
    count_d  = count_q;
    status_d = bdeq_pkg::ST_OK;
    data_d   = '0;
    unique case (bdeq_pkg::action_e'(action_i))
      bdeq_pkg::ACT_INS_FRONT: begin
        if (full) begin
          status_d = bdeq_pkg::ST_FULL;
        end else begin
          cmd.shift_right = 1'b1;
          count_d         = count_q + CntW'(1);
        end
      end
      bdeq_pkg::ACT_INS_BACK: begin
        if (full) begin
          status_d = bdeq_pkg::ST_FULL;
        end else begin
          cmd.write_back = 1'b1;
          count_d        = count_q + CntW'(1);
        end
      end
      bdeq_pkg::ACT_REM_FRONT: begin
        if (empty) begin
          status_d = bdeq_pkg::ST_EMPTY;
        end else begin
          data_d         = front_i;
          cmd.shift_left = 1'b1;
          count_d        = count_q - CntW'(1);
        end
      end
      bdeq_pkg::ACT_REM_BACK: begin
        if (empty) begin
          status_d = bdeq_pkg::ST_EMPTY;
        end else begin
          data_d  = back_i;
          count_d = count_q - CntW'(1);
        end
      end
      bdeq_pkg::ACT_PEEK_FRONT: begin
        if (empty) begin
          status_d = bdeq_pkg::ST_EMPTY;
        end else begin
          data_d = front_i;
        end
      end
      bdeq_pkg::ACT_PEEK_BACK: begin
        if (empty) begin
          status_d = bdeq_pkg::ST_EMPTY;
        end else begin
          data_d = back_i;
        end
      end
      default: begin
        // unused codes: no operation, report the queue as it is
      end
    endcase
  end

  assign cmd_o       = accept ? cmd : '0;
  assign out_valid_d = accept || (out_valid_q && out_stall_i);
  assign occ_wide    = {{OccW{1'b0}}, count_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        count_q <= count_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      data_q   <= data_d;
      occ_q    <= occ_wide[OccW-1:0];
      empty_q  <= (count_d == '0);
      full_q   <= (count_d == CntW'(DEPTH));
    end
  end

  assign count_o         = count_q;
  assign out_valid_o     = out_valid_q;
  assign status_o        = status_q;
  assign data_out_o      = data_q;
  assign occupancy_o     = occ_q;
  assign is_empty_flag_o = empty_q;
  assign is_full_flag_o  = full_q;

endmodule

`default_nettype wire

/* test/deque_checker.sv */
// Checker for the bounded double-ended queue: predicts each result and compares it.
module deque_checker #(
  parameter int DEPTH = bdeq_pkg::DEFAULT_DEPTH
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  input  wire                                 in_stall_i,
  input  wire [bdeq_pkg::ACTION_W-1:0]        action_i,
  input  wire signed [bdeq_pkg::DATA_W-1:0]   data_in_i,
  input  wire                                 out_valid_i,
  input  wire                                 out_stall_i,
  input  wire [bdeq_pkg::STATUS_W-1:0]        status_i,
  input  wire signed [bdeq_pkg::DATA_W-1:0]   data_out_i,
  input  wire [bdeq_pkg::OCC_W-1:0]           occupancy_i,
  input  wire                                 is_empty_flag_i,
  input  wire                                 is_full_flag_i,
  output int                                  mismatches_o,
  output int                                  pending_o
);

  import bdeq_pkg::*;

  typedef struct packed {
    status_e                    status;
    logic signed [DATA_W-1:0]   value;
    logic [OCC_W-1:0]           occupancy;
    logic                       empty;
    logic                       full;
  } deque_result_t;

  // Mirror of the queue: circular store addressed from the front slot.
  logic signed [DATA_W-1:0] mirror_store [DEPTH];
  int unsigned              mirror_head;
  int unsigned              mirror_count;

  deque_result_t            expected_results [$];
  deque_result_t            oldest;
  int                       mismatch_total = 0;

  function automatic deque_result_t apply_deque_op(input logic [ACTION_W-1:0] act,
                                                   input logic signed [DATA_W-1:0] val);
    deque_result_t r;
    int unsigned   tail;
    r = '0;
    r.status = ST_OK;
    tail = (mirror_head + mirror_count + DEPTH - 1) % DEPTH;
    case (act)
      ACT_INS_FRONT, ACT_INS_BACK: begin
        if (mirror_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (act == ACT_INS_FRONT) begin
            mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
            mirror_store[mirror_head] = val;
          end else begin
            mirror_store[(mirror_head + mirror_count) % DEPTH] = val;
          end
          mirror_count++;
        end
      end
      ACT_REM_FRONT, ACT_REM_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (mirror_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          if (act == ACT_REM_FRONT || act == ACT_PEEK_FRONT) r.value = mirror_store[mirror_head];
          else r.value = mirror_store[tail];
          if (act == ACT_REM_FRONT) mirror_head = (mirror_head + 1) % DEPTH;
          if (act == ACT_REM_FRONT || act == ACT_REM_BACK) mirror_count--;
        end
      end
      default: ;  // reserved codes: no operation
    endcase
    r.occupancy = OCC_W'(mirror_count);
    r.empty     = (mirror_count == 0);
    r.full      = (mirror_count == DEPTH);
    return r;
  endfunction

  task automatic check_field(input string field, input logic [DATA_W-1:0] want,
                             input logic [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want, got);
      mismatch_total++;
    end
  endtask

  // Results are registered in the block, so the
  // output side is handled before this edge's input transfer is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_results.delete();
      mirror_head  = 0;
      mirror_count = 0;
      pending_o    <= 0;
      mismatches_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result expected none got status %0h data %0h occupancy %0h",
                   $time, status_i, data_out_i, occupancy_i);
          mismatch_total++;
        end else begin
          oldest = expected_results.pop_front();
          check_field("status", oldest.status, status_i);
          check_field("data_out", oldest.value, data_out_i);
          check_field("occupancy", oldest.occupancy, occupancy_i);
          check_field("is_empty_flag", oldest.empty, is_empty_flag_i);
          check_field("is_full_flag", oldest.full, is_full_flag_i);
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_results.push_back(apply_deque_op(action_i, data_in_i));
      pending_o    <= expected_results.size();
      mismatches_o <= mismatch_total;
    end
  end

endmodule

/* test/tb.sv */
// Testbench top for the bounded double-ended queue: stimulus, stall pattern and verdict.
module tb;

  import bdeq_pkg::*;

  localparam int DEPTH        = DEFAULT_DEPTH;
  localparam int RANDOM_OPS   = 1300;
  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE       = 8;

  // The action field has two codes with no operation behind them.
  localparam logic [ACTION_W-1:0] ACT_RESERVED_A = ACTION_W'(6);
  localparam logic [ACTION_W-1:0] ACT_RESERVED_B = ACTION_W'(7);

  typedef enum int {SEQ_FILL, SEQ_DRAIN, SEQ_MIXED} seq_kind_e;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_e;

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_stall;
  logic [ACTION_W-1:0]       action;
  logic signed [DATA_W-1:0]  data_in;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic [STATUS_W-1:0]       status;
  logic signed [DATA_W-1:0]  data_out;
  logic [OCC_W-1:0]          occupancy;
  logic                      empty_flag;
  logic                      full_flag;

  int                        mismatches;
  int                        pending_results;

  // Sender burst bookkeeping.
  int                        ops_sent   = 0;
  int                        burst_left = 5;

  // Receiver stall pattern state.
  stall_mode_e               stall_mode = STALL_NONE;
  int unsigned               stall_left = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  bounded_double_ended_queue #(
    .DEPTH (DEPTH)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .action_i        (action),
    .data_in_i       (data_in),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .status_o        (status),
    .data_out_o      (data_out),
    .occupancy_o     (occupancy),
    .is_empty_flag_o (empty_flag),
    .is_full_flag_o  (full_flag)
  );

  deque_checker #(
    .DEPTH (DEPTH)
  ) i_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_i      (in_stall),
    .action_i        (action),
    .data_in_i       (data_in),
    .out_valid_i     (out_valid),
    .out_stall_i     (out_stall),
    .status_i        (status),
    .data_out_i      (data_out),
    .occupancy_i     (occupancy),
    .is_empty_flag_i (empty_flag),
    .is_full_flag_i  (full_flag),
    .mismatches_o    (mismatches),
    .pending_o       (pending_results)
  );

  // Receiver: picks a stall mode and holds it for a random stretch. The
  // no-stall mode gives long runs at full rate; the long mode holds results
  // for the most part, so the input side backs up too.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
      stall_left <= $urandom_range(10, 120);
      out_stall  <= 1'b0;
    end else begin
      stall_left <= stall_left - 1;
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_RANDOM:   out_stall <= ($urandom_range(0, 9) < 4);
        STALL_PERIODIC: out_stall <= ((stall_left % 5) < 3);
        default:        out_stall <= ((stall_left % 24) >= 4);
      endcase
    end
  end

  // Values lean on the extremes of the signed range, zero, -1 and small values; the rest is uniform.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2:       return '0;
      3:       return -1;
      4:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // Fill sequences mostly insert, drain sequences mostly remove, so the queue
  // swings between full and empty and hits both rejections regularly.
  function automatic logic [ACTION_W-1:0] pick_action(input seq_kind_e kind);
    int unsigned roll;
    int unsigned ins_top;
    int unsigned rem_top;
    logic        at_back;
    roll    = $urandom_range(0, 99);
    at_back = 1'($urandom_range(0, 1));
    case (kind)
      SEQ_FILL: begin
        ins_top = 80;
        rem_top = 90;
      end
      SEQ_DRAIN: begin
        ins_top = 15;
        rem_top = 85;
      end
      default: begin
        ins_top = 40;
        rem_top = 75;
      end
    endcase
    if (roll < 3)             return at_back ? ACT_RESERVED_B : ACT_RESERVED_A;
    else if (roll < ins_top)  return at_back ? ACT_INS_BACK : ACT_INS_FRONT;
    else if (roll < rem_top)  return at_back ? ACT_REM_BACK : ACT_REM_FRONT;
    else                      return at_back ? ACT_PEEK_BACK : ACT_PEEK_FRONT;
  endfunction

  // One input transfer. Valid stays up across a burst and only drops for a
  // gap, so it is never lowered and raised at the same edge.
  task automatic send_op(input logic [ACTION_W-1:0] act, input logic signed [DATA_W-1:0] val);
    int gap;
    in_valid <= 1'b1;
    action   <= act;
    data_in  <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ops_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold the sender off until every outstanding result has been seen.
  // The pending count is registered, so it is first read at the edge after the last send.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  // Run limit: a hung handshake or a missing result ends here.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : stimulus
    seq_kind_e kind;
    int        seq_len;
    int        random_start;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    action   = ACT_INS_FRONT;
    data_in  = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every operation on an empty queue, the reserved codes, extreme
    // values at both ends, front insert wrapping the front slot backwards,
    // and a lone entry removed from each end.
    send_op(ACT_PEEK_FRONT, '0);
    send_op(ACT_PEEK_BACK, '0);
    send_op(ACT_REM_FRONT, '0);
    send_op(ACT_REM_BACK, '0);
    send_op(ACT_RESERVED_A, 32'sh7fffffff);
    send_op(ACT_RESERVED_B, 32'sh80000000);
    send_op(ACT_INS_FRONT, 32'sh7fffffff);
    send_op(ACT_INS_BACK, 32'sh80000000);
    send_op(ACT_INS_FRONT, '0);
    send_op(ACT_INS_BACK, -1);
    send_op(ACT_PEEK_FRONT, -1);
    send_op(ACT_PEEK_BACK, '0);
    send_op(ACT_RESERVED_A, -1);
    send_op(ACT_REM_BACK, '0);
    send_op(ACT_REM_FRONT, '0);
    send_op(ACT_REM_FRONT, '0);
    send_op(ACT_REM_BACK, '0);
    send_op(ACT_REM_FRONT, '0);
    send_op(ACT_INS_BACK, 32'sh00000001);
    send_op(ACT_PEEK_FRONT, '0);
    send_op(ACT_REM_FRONT, '0);
    wait_for_drain();

    // Random: sequences of one kind each, with an occasional full drain.
    random_start = ops_sent;
    while (ops_sent - random_start < RANDOM_OPS) begin
      kind    = seq_kind_e'($urandom_range(0, 2));
      seq_len = $urandom_range(8, 40);
      repeat (seq_len) send_op(pick_action(kind), pick_value());
      if ($urandom_range(0, 11) == 0) wait_for_drain();
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
hdl/bdeq_pkg.sv
hdl/bdeq_cell.sv
hdl/bdeq_ctrl.sv
hdl/bounded_double_ended_queue.sv
test/deque_checker.sv
test/tb.sv
